/* rtl/kmrp_pkg.sv */
package kmrp_pkg;

    // Fixed-width fields and register layout
    localparam int LEVEL_W    = 24;   // rms_level / peak_level width
    localparam int COEF_FRAC  = 24;   // Q0.24 coefficients
    localparam int CNT_W      = 16;   // sample counter / period length
    localparam int HOLD_W     = 24;   // hold counter
    localparam int FCOEF_W    = 22;   // filter_coef register width
    localparam int HSAMP_W    = 22;   // hold_samples register width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_COEF    = 2'd3;

    // Reset values of the configuration registers
    localparam logic [FCOEF_W-1:0]   RST_FILTER_COEF  = 22'd3397;
    localparam logic [HSAMP_W-1:0]   RST_HOLD_SAMPLES = 22'd72000;
    localparam logic [CNT_W-1:0]     RST_PERIOD_LEN   = 16'd256;
    localparam logic [COEF_FRAC-1:0] RST_FALL_COEF    = 24'd16725876;

    // Square root unit: 48-bit radicand, 2 bits per step
    localparam int SQRT_RAD_W  = 48;
    localparam int SQRT_ROOT_W = 24;
    localparam int SQRT_STEPS  = SQRT_RAD_W / 2;
    localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE         = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD         = 4'd1;
    localparam logic [OP_W-1:0] OP_READ         = 4'd2;
    localparam logic [OP_W-1:0] OP_SQUARE       = 4'd3;
    localparam logic [OP_W-1:0] OP_DIFF         = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL_LO       = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL_HI       = 4'd6;
    localparam logic [OP_W-1:0] OP_UPDATE       = 4'd7;
    localparam logic [OP_W-1:0] OP_PERIOD_START = 4'd8;
    localparam logic [OP_W-1:0] OP_PERIOD_DONE  = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            second;   // filter op targets the second low-pass
    } cmd_t;

    typedef struct packed {
        logic out_free;     // output register can take a result this cycle
        logic quarter;      // sample count is a multiple of four
        logic period_end;   // sample count reached the period length
        logic sqrt_busy;
    } status_t;

endpackage

/* rtl/kmrp_isqrt.sv */
module kmrp_isqrt (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [kmrp_pkg::SQRT_RAD_W-1:0]    radicand,
    output logic                               busy,
    output logic [kmrp_pkg::SQRT_ROOT_W-1:0]   root
);
    import kmrp_pkg::*;

    localparam int REM_W = SQRT_ROOT_W + 2;

    logic [SQRT_RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [SQRT_ROOT_W-1:0] root_reg;
    logic [SQRT_CNT_W-1:0]  cnt_reg;
    logic                   busy_reg;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             fits;

    // one result digit per step (restoring, radix 4 on the radicand)
    assign rem_sh = {rem_reg, rad_reg[SQRT_RAD_W-1 -: 2]};
    assign trial  = (REM_W+2)'({root_reg, 2'b01});
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[SQRT_RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[SQRT_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_sh);
                root_reg <= {root_reg[SQRT_ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

/* rtl/kmrp_datapath.sv */
module kmrp_datapath #(
    parameter int SAMPLE_BITS = 24,
    parameter int FILTER_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [kmrp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kmrp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    input  logic                              out_ready,
    input  kmrp_pkg::cmd_t                    cmd,
    output kmrp_pkg::status_t                 status,
    output logic                              out_valid,
    output logic [kmrp_pkg::LEVEL_W-1:0]      rms_level,
    output logic [kmrp_pkg::LEVEL_W-1:0]      peak_level
);
    import kmrp_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int FB = FILTER_BITS;
    localparam int MW = (SB > COEF_FRAC) ? SB : COEF_FRAC;   // multiplier operand width
    localparam int PW = 2 * MW;

    // configuration
    logic [FCOEF_W-1:0]   filter_coef_reg;
    logic [HSAMP_W-1:0]   hold_samples_reg;
    logic [CNT_W-1:0]     period_len_reg;
    logic [COEF_FRAC-1:0] fall_coef_reg;

    // meter state
    logic [FB-1:0]      lp1_reg;
    logic [FB-1:0]      lp2_reg;
    logic [LEVEL_W-1:0] max_mag_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [LEVEL_W-1:0] rms_hold_reg;
    logic [LEVEL_W-1:0] peak_hold_reg;
    logic [HOLD_W-1:0]  hold_count_reg;
    logic               read_pending_reg;

    // working registers
    logic [SB-1:0]        mag_reg;
    logic [PW-1:0]        prod_reg;
    logic [FB-1:0]        diff_reg;
    logic                 neg_reg;
    logic [COEF_FRAC-1:0] acc_reg;

    // output register
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] rms_out_reg;
    logic [LEVEL_W-1:0] peak_out_reg;

    logic [SB-1:0]             raw_w;
    logic [SB-1:0]             mag_w;
    logic [SB+LEVEL_W-1:0]     pk_ext;
    logic [LEVEL_W-1:0]        pk_w;
    logic [2*SB-1:0]           sq_w;
    logic [2*SB+FB+1:0]        tgt_ext;
    logic [FB:0]               tgt_wide;
    logic [FB-1:0]             tgt_w;
    logic [COEF_FRAC-1:0]      coef_w;
    logic [FB-1:0]             z_sel;
    logic [FB-1:0]             target_sel;
    logic [MW-1:0]             mul_a;
    logic [MW-1:0]             mul_b;
    logic [PW-1:0]             product;
    logic [2*COEF_FRAC:0]      step_sum;
    logic [FB-1:0]             step_w;
    logic [CNT_W-1:0]          len_w;
    logic [FB+22:0]            rad_ext;
    logic [SQRT_RAD_W-1:0]     rad_w;
    logic [SQRT_ROOT_W-1:0]    root_w;
    logic                      sqrt_busy;
    logic [LEVEL_W-1:0]        decay_w;
    logic [HOLD_W-1:0]         hold_dec;
    logic                      out_free;
    logic                      sqrt_start;

    // sample magnitude; the most negative code gives 2^(SB-1)
    assign raw_w = sample;
    assign mag_w = raw_w[SB-1] ? (~raw_w + SB'(1)) : raw_w;

    // magnitude rescaled to Q0.23
    assign pk_ext = {mag_w, {LEVEL_W{1'b0}}};
    assign pk_w   = LEVEL_W'(pk_ext >> SB);

    // squared sample as a filter target, saturating at all ones
    assign sq_w     = prod_reg[2*SB-1:0];
    assign tgt_ext  = {sq_w, {(FB+2){1'b0}}};
    assign tgt_wide = (FB+1)'(tgt_ext >> (2*SB));
    assign tgt_w    = tgt_wide[FB] ? {FB{1'b1}} : tgt_wide[FB-1:0];

    // second filter runs at four times the coefficient
    assign coef_w     = cmd.second ? {filter_coef_reg, 2'b00} : {2'b00, filter_coef_reg};
    assign z_sel      = cmd.second ? lp2_reg : lp1_reg;
    assign target_sel = cmd.second ? lp1_reg : tgt_w;

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SQUARE:
            begin
                mul_a = MW'(mag_reg);
                mul_b = MW'(mag_reg);
            end
            OP_MUL_LO:
            begin
                mul_a = MW'(diff_reg[COEF_FRAC-1:0]);
                mul_b = MW'(coef_w);
            end
            OP_MUL_HI:
            begin
                mul_a = MW'(diff_reg >> COEF_FRAC);
                mul_b = MW'(coef_w);
            end
            OP_PERIOD_START:
            begin
                mul_a = MW'(peak_hold_reg);
                mul_b = MW'(fall_coef_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // filter step: (diff * coef) >> 24 = hi*coef + (lo*coef >> 24)
    assign step_sum = (2*COEF_FRAC+1)'(prod_reg[2*COEF_FRAC-1:0])
                    + (2*COEF_FRAC+1)'(acc_reg);
    assign step_w   = FB'(step_sum);

    // effective period length: multiple of four, at least four
    assign len_w = (period_len_reg[CNT_W-1:2] == '0) ? CNT_W'(4)
                 : {period_len_reg[CNT_W-1:2], 2'b00};

    // RMS radicand: 2 * lp2 scaled to Q.46
    assign rad_ext = {lp2_reg, 23'b0};
    assign rad_w   = SQRT_RAD_W'(rad_ext >> (FB - 24));

    assign decay_w  = prod_reg[2*COEF_FRAC-1:COEF_FRAC];
    assign hold_dec = (hold_count_reg > HOLD_W'(len_w)) ? hold_count_reg - HOLD_W'(len_w) : '0;

    assign sqrt_start = (cmd.op == OP_PERIOD_START);

    kmrp_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (rad_w),
        .busy     (sqrt_busy),
        .root     (root_w)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_coef_reg  <= RST_FILTER_COEF;
            hold_samples_reg <= RST_HOLD_SAMPLES;
            period_len_reg   <= RST_PERIOD_LEN;
            fall_coef_reg    <= RST_FALL_COEF;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FILTER_COEF:  filter_coef_reg  <= cfg_wdata[FCOEF_W-1:0];
                CFG_HOLD_SAMPLES: hold_samples_reg <= cfg_wdata[HSAMP_W-1:0];
                CFG_PERIOD_LEN:   period_len_reg   <= cfg_wdata[CNT_W-1:0];
                CFG_FALL_COEF:    fall_coef_reg    <= cfg_wdata[COEF_FRAC-1:0];
            endcase
        end
    end

    // meter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp1_reg          <= '0;
            lp2_reg          <= '0;
            max_mag_reg      <= '0;
            count_reg        <= '0;
            rms_hold_reg     <= '0;
            peak_hold_reg    <= '0;
            hold_count_reg   <= '0;
            read_pending_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    count_reg <= count_reg + 1'b1;
                    if (pk_w > max_mag_reg)
                    begin
                        max_mag_reg <= pk_w;
                    end
                end
                OP_READ:
                begin
                    read_pending_reg <= 1'b1;
                end
                OP_UPDATE:
                begin
                    if (cmd.second)
                    begin
                        lp2_reg <= neg_reg ? lp2_reg - step_w : lp2_reg + step_w;
                    end
                    else
                    begin
                        lp1_reg <= neg_reg ? lp1_reg - step_w : lp1_reg + step_w;
                    end
                end
                OP_PERIOD_DONE:
                begin
                    count_reg   <= '0;
                    max_mag_reg <= '0;
                    // a read since the last period end restarts the RMS maximum
                    if (read_pending_reg)
                    begin
                        rms_hold_reg     <= root_w;
                        read_pending_reg <= 1'b0;
                    end
                    else if (root_w > rms_hold_reg)
                    begin
                        rms_hold_reg <= root_w;
                    end
                    // new peak rearms the hold; otherwise count down, then decay
                    if (max_mag_reg >= peak_hold_reg)
                    begin
                        peak_hold_reg  <= max_mag_reg;
                        hold_count_reg <= HOLD_W'(hold_samples_reg);
                    end
                    else if (hold_count_reg != '0)
                    begin
                        hold_count_reg <= hold_dec;
                    end
                    else
                    begin
                        peak_hold_reg <= decay_w;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            mag_reg <= mag_w;
        end
        if (cmd.op == OP_SQUARE || cmd.op == OP_MUL_LO || cmd.op == OP_MUL_HI
            || cmd.op == OP_PERIOD_START)
        begin
            prod_reg <= product;
        end
        if (cmd.op == OP_MUL_HI)
        begin
            acc_reg <= prod_reg[2*COEF_FRAC-1:COEF_FRAC];
        end
        if (cmd.op == OP_DIFF)
        begin
            if (target_sel >= z_sel)
            begin
                diff_reg <= target_sel - z_sel;
                neg_reg  <= 1'b0;
            end
            else
            begin
                diff_reg <= z_sel - target_sel;
                neg_reg  <= 1'b1;
            end
        end
    end

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_READ)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_READ)
        begin
            rms_out_reg  <= rms_hold_reg;
            peak_out_reg <= peak_hold_reg;
        end
    end

    assign status.out_free   = out_free;
    assign status.quarter    = (count_reg[1:0] == 2'b00);
    assign status.period_end = (count_reg >= len_w);
    assign status.sqrt_busy  = sqrt_busy;

    assign out_valid  = out_valid_reg;
    assign rms_level  = rms_out_reg;
    assign peak_level = peak_out_reg;

endmodule

/* rtl/kmrp_ctrl.sv */
module kmrp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              action,
    input  kmrp_pkg::status_t status,
    output logic              in_ready,
    output kmrp_pkg::cmd_t    cmd
);
    import kmrp_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SQUARE = 3'd1;
    localparam logic [2:0] S_DIFF   = 3'd2;
    localparam logic [2:0] S_MUL_LO = 3'd3;
    localparam logic [2:0] S_MUL_HI = 3'd4;
    localparam logic [2:0] S_UPDATE = 3'd5;
    localparam logic [2:0] S_PSTART = 3'd6;
    localparam logic [2:0] S_PWAIT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       second_reg;
    logic       second_next;

    // a read needs room in the output register; a sample does not
    assign in_ready = (state_reg == S_IDLE) && (!action || status.out_free);

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        cmd.op      = OP_NONE;
        cmd.second  = second_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (action)
                    begin
                        cmd.op = OP_READ;
                    end
                    else
                    begin
                        cmd.op      = OP_LOAD;
                        second_next = 1'b0;
                        state_next  = S_SQUARE;
                    end
                end
            end
            S_SQUARE:
            begin
                cmd.op     = OP_SQUARE;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.op     = OP_MUL_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.op     = OP_MUL_HI;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.op = OP_UPDATE;
                priority if (!second_reg && status.quarter)
                begin
                    second_next = 1'b1;
                    state_next  = S_DIFF;
                end
                else if (status.period_end)
                begin
                    state_next = S_PSTART;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PSTART:
            begin
                cmd.op     = OP_PERIOD_START;
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (!status.sqrt_busy)
                begin
                    cmd.op     = OP_PERIOD_DONE;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

endmodule

/* rtl/k_meter_rms_peak_core.sv */
// Channel   Signals                          Direction  Item
// input     in_valid/in_ready, action,sample in         sample or read request
// output    out_valid/out_ready, rms_level,  out        held RMS and peak (reads only)
//           peak_level
// config    cfg_wr_en, cfg_index, cfg_wdata  in         register write, no handshake
//
// Steps: a read is done in the idle state. A sample runs the first low-pass, and
// the second too when the count hits a multiple of four, plus at a period end the
// 24-step square root unit. All multiplies share one registered multiplier.
// Reset: asynchronous, clears all meter state and loads the register defaults.
// Stalls: in_ready drops while a sample is in work; a read also waits for room in
// the output register, while samples keep flowing behind a held result.
module k_meter_rms_peak_core #(
    parameter int SAMPLE_BITS = 24,
    parameter int FILTER_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [kmrp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kmrp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [kmrp_pkg::LEVEL_W-1:0]      rms_level,
    output logic [kmrp_pkg::LEVEL_W-1:0]      peak_level
);
    import kmrp_pkg::*;

    cmd_t    cmd;      // controller -> datapath
    status_t status;   // datapath -> controller

    // Sequencer: accept, square, then per filter diff / lo mul / hi mul / update,
    // then at period end the peak decay multiply and square root.
    kmrp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Filters, peak tracking, hold logic, square root, config registers and the output register.
    kmrp_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FILTER_BITS (FILTER_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .sample     (sample),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .rms_level  (rms_level),
        .peak_level (peak_level)
    );

`ifndef SYNTH
    // a read item always lands in the output register
    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action |=> out_valid)
        else $error("read item produced no result");

    // a sample item keeps the sequencer busy, so in_ready stays low after it is taken
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !action |=> !in_ready)
        else $error("input accepted while a sample is in work");

    // held peak never exceeds full scale
    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> peak_level <= 24'd8388608)
        else $error("peak level above full scale");

    // RMS of a Q0 filter value is bounded by sqrt(2)
    a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rms_level <= 24'd11863283)
        else $error("rms level out of range");
`endif

endmodule
